[rtl/rorc_pkg.sv]
// Package with the command codes and controller states of the occupancy range counter.
package rorc_pkg;

  // Command codes carried on the request's cmd field.
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_RC_WAIT,
    S_UP_RD,
    S_UP_WR,
    S_Q_A,
    S_Q_B,
    S_Q_SH,
    S_Q_FIN,
    S_D_RD,
    S_D_CHK,
    S_DONE
  } state_t;

endpackage

[rtl/refcount_occupancy_range_counter.sv]
// Reference counter with occupancy bits and a memory-based sum tree for range queries.
//
// Usage: one request channel (in_*) carries a command with a position or an inclusive
// range; one result channel (out_*) returns exactly one result per request, in order.
// Add and remove change a saturating per-position count; when the count leaves or
// returns to zero, the leaf of the sum tree and all its ancestors are updated by a
// read-modify-write per node (states S_UP_RD and S_UP_WR per level). A query walks
// the tree bottom-up (S_Q_A, S_Q_B and S_Q_SH per level), then descends from the
// leftmost non-empty covering node to the first occupied leaf (S_D_RD and S_D_CHK
// per level). The tree memory has a single read port. Only one request is worked
// on at a time. After reset the block sweeps both memories to zero, one entry
// per cycle, while in_stall is held high. A finished result sits in an output
// register; while out_stall is high it holds and the next request is already
// accepted and worked on, waiting before delivery until the register is free.
module refcount_occupancy_range_counter #(
  parameter int POSITIONS  = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [9:0]  in_pos,
  input  logic [9:0]  in_range_low,
  input  logic [9:0]  in_range_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_occupied_count,
  output logic        out_found,
  output logic [9:0]  out_first_pos,
  output logic        out_error
);

  localparam int PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int NW = $clog2(2 * POSITIONS);
  localparam int BW = $clog2(2 * POSITIONS + 1);
  localparam int SW = $clog2(POSITIONS + 1);
  localparam logic [BW-1:0] P_B = BW'(POSITIONS);
  localparam logic [NW-1:0] P_N = NW'(POSITIONS);
  localparam logic [NW-1:0] CLR_LAST = NW'(2 * POSITIONS - 1);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  rorc_pkg::state_t state_r, state_nxt;

  // Memories.
  logic [COUNT_BITS-1:0] rc_mem [POSITIONS];
  logic [SW-1:0]         tr_mem [2*POSITIONS];
  logic [COUNT_BITS-1:0] rc_rdata_r;
  logic [SW-1:0]         tr_rdata_r;

  // Memory port controls.
  logic                  rc_re, rc_we, tr_re, tr_we;
  logic [PW-1:0]         rc_raddr, rc_waddr;
  logic [COUNT_BITS-1:0] rc_wdata;
  logic [NW-1:0]         tr_raddr, tr_waddr;
  logic [SW-1:0]         tr_wdata;

  // Request and working registers.
  rorc_pkg::cmd_t cmd_r;
  logic [9:0]     pos_r, lo_r, hi_r;
  logic [NW-1:0]  clr_cnt_r;
  logic [NW-1:0]  node_r;
  logic           inc_r;
  logic [BW-1:0]  a_r, b_r;
  logic           rd_pend_r, rd_left_r;
  logic [NW-1:0]  rd_node_r;
  logic           lc_vld_r, rc_vld_r;
  logic [NW-1:0]  lc_node_r, rc_node_r;
  logic [SW-1:0]  sum_r;
  logic           res_found_r, res_err_r;
  logic [9:0]     res_first_r;
  logic           out_valid_r;

  // Decoded request values.
  logic          pos_ok;
  logic [BW-1:0] hi_clip;
  logic [PW-1:0] pos_idx;
  logic          leaf_flip;
  logic          ref_chg;

  assign pos_ok  = 32'(pos_r) < POSITIONS;
  assign pos_idx = PW'(pos_r);
  assign hi_clip = (32'(hi_r) > POSITIONS - 1) ? BW'(POSITIONS - 1) : BW'(hi_r);

  // Count update decision once the stored count is back.
  always_comb begin
    leaf_flip = 1'b0;
    ref_chg   = 1'b0;
    if (cmd_r == rorc_pkg::CMD_ADD) begin
      ref_chg   = rc_rdata_r != CMAX;
      leaf_flip = rc_rdata_r == '0;
    end else begin
      ref_chg   = rc_rdata_r != '0;
      leaf_flip = rc_rdata_r == COUNT_BITS'(1);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rorc_pkg::S_CLEAR: if (clr_cnt_r == CLR_LAST) state_nxt = rorc_pkg::S_IDLE;
      rorc_pkg::S_IDLE:  if (in_valid) state_nxt = rorc_pkg::S_DEC;
      rorc_pkg::S_DEC: begin
        unique case (cmd_r)
          rorc_pkg::CMD_ADD, rorc_pkg::CMD_REMOVE:
            state_nxt = pos_ok ? rorc_pkg::S_RC_WAIT : rorc_pkg::S_DONE;
          rorc_pkg::CMD_QUERY:
            state_nxt = (BW'(lo_r) <= hi_clip) ? rorc_pkg::S_Q_A : rorc_pkg::S_DONE;
          default: state_nxt = rorc_pkg::S_DONE;
        endcase
      end
      rorc_pkg::S_RC_WAIT:
        state_nxt = (ref_chg && leaf_flip) ? rorc_pkg::S_UP_RD : rorc_pkg::S_DONE;
      rorc_pkg::S_UP_RD: state_nxt = rorc_pkg::S_UP_WR;
      rorc_pkg::S_UP_WR:
        state_nxt = (node_r == NW'(1)) ? rorc_pkg::S_DONE : rorc_pkg::S_UP_RD;
      rorc_pkg::S_Q_A: state_nxt = (a_r >= b_r) ? rorc_pkg::S_Q_FIN : rorc_pkg::S_Q_B;
      rorc_pkg::S_Q_B: state_nxt = rorc_pkg::S_Q_SH;
      rorc_pkg::S_Q_SH: state_nxt = rorc_pkg::S_Q_A;
      rorc_pkg::S_Q_FIN:
        state_nxt = (lc_vld_r || rc_vld_r) ? rorc_pkg::S_D_RD : rorc_pkg::S_DONE;
      rorc_pkg::S_D_RD: state_nxt = (node_r >= P_N) ? rorc_pkg::S_DONE : rorc_pkg::S_D_CHK;
      rorc_pkg::S_D_CHK: state_nxt = rorc_pkg::S_D_RD;
      rorc_pkg::S_DONE: if (!out_valid_r || !out_stall) state_nxt = rorc_pkg::S_IDLE;
      default: state_nxt = rorc_pkg::S_CLEAR;
    endcase
  end

  // Memory port controls for each state.
  always_comb begin
    rc_re    = 1'b0;
    rc_raddr = pos_idx;
    rc_we    = 1'b0;
    rc_waddr = pos_idx;
    rc_wdata = (cmd_r == rorc_pkg::CMD_ADD) ? rc_rdata_r + 1'b1 : rc_rdata_r - 1'b1;
    tr_re    = 1'b0;
    tr_raddr = node_r;
    tr_we    = 1'b0;
    tr_waddr = node_r;
    tr_wdata = inc_r ? tr_rdata_r + 1'b1 : tr_rdata_r - 1'b1;
    unique case (state_r)
      rorc_pkg::S_CLEAR: begin
        tr_we    = 1'b1;
        tr_waddr = clr_cnt_r;
        tr_wdata = '0;
        rc_we    = clr_cnt_r < P_N;
        rc_waddr = PW'(clr_cnt_r);
        rc_wdata = '0;
      end
      rorc_pkg::S_DEC: rc_re = pos_ok && (cmd_r == rorc_pkg::CMD_ADD ||
                                          cmd_r == rorc_pkg::CMD_REMOVE);
      rorc_pkg::S_RC_WAIT: rc_we = ref_chg;
      rorc_pkg::S_UP_RD: tr_re = 1'b1;
      rorc_pkg::S_UP_WR: tr_we = 1'b1;
      rorc_pkg::S_Q_A: begin
        tr_re    = (a_r < b_r) && a_r[0];
        tr_raddr = NW'(a_r);
      end
      rorc_pkg::S_Q_B: begin
        tr_re    = b_r[0];
        tr_raddr = NW'(b_r - 1'b1);
      end
      rorc_pkg::S_D_RD: begin
        tr_re    = node_r < P_N;
        tr_raddr = {node_r[NW-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  // Synchronous memories with registered read data.
  always_ff @(posedge clk) begin
    if (rc_we) rc_mem[rc_waddr] <= rc_wdata;
    if (rc_re) rc_rdata_r <= rc_mem[rc_raddr];
    if (tr_we) tr_mem[tr_waddr] <= tr_wdata;
    if (tr_re) tr_rdata_r <= tr_mem[tr_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rorc_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= tr_re && (state_r == rorc_pkg::S_Q_A || state_r == rorc_pkg::S_Q_B);
      if (state_r == rorc_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == rorc_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == rorc_pkg::S_IDLE && in_valid) begin
      cmd_r <= rorc_pkg::cmd_t'(in_cmd);
      pos_r <= in_pos;
      lo_r  <= in_range_low;
      hi_r  <= in_range_high;
    end
    // Accumulate tree nodes read during the range walk.
    if (rd_pend_r) begin
      sum_r <= sum_r + tr_rdata_r;
      if (tr_rdata_r != '0) begin
        if (rd_left_r && !lc_vld_r) begin
          lc_vld_r  <= 1'b1;
          lc_node_r <= rd_node_r;
        end else if (!rd_left_r) begin
          rc_vld_r  <= 1'b1;
          rc_node_r <= rd_node_r;
        end
      end
    end
    unique case (state_r)
      rorc_pkg::S_DEC: begin
        sum_r       <= '0;
        res_found_r <= 1'b0;
        res_first_r <= '0;
        res_err_r   <= 1'b0;
        lc_vld_r    <= 1'b0;
        rc_vld_r    <= 1'b0;
        a_r         <= BW'(lo_r) + P_B;
        b_r         <= hi_clip + P_B + 1'b1;
      end
      rorc_pkg::S_RC_WAIT: begin
        res_err_r <= (cmd_r == rorc_pkg::CMD_REMOVE) && (rc_rdata_r == '0);
        node_r    <= P_N + NW'(pos_r);
        inc_r     <= cmd_r == rorc_pkg::CMD_ADD;
      end
      rorc_pkg::S_UP_WR: node_r <= node_r >> 1;
      rorc_pkg::S_Q_A: begin
        rd_left_r <= 1'b1;
        rd_node_r <= NW'(a_r);
        if (a_r < b_r && a_r[0]) a_r <= a_r + 1'b1;
      end
      rorc_pkg::S_Q_B: begin
        rd_left_r <= 1'b0;
        rd_node_r <= NW'(b_r - 1'b1);
        if (b_r[0]) b_r <= b_r - 1'b1;
      end
      rorc_pkg::S_Q_SH: begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
      end
      rorc_pkg::S_Q_FIN: begin
        node_r      <= lc_vld_r ? lc_node_r : rc_node_r;
        res_found_r <= lc_vld_r || rc_vld_r;
      end
      rorc_pkg::S_D_RD: if (node_r >= P_N) res_first_r <= 10'(node_r - P_N);
      rorc_pkg::S_D_CHK: node_r <= {node_r[NW-2:0], (tr_rdata_r == '0)};
      default: ;
    endcase
  end

  // Output register, loaded when the result register is free.
  always_ff @(posedge clk) begin
    if (state_r == rorc_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
      out_occupied_count <= 11'(sum_r);
      out_found          <= res_found_r;
      out_first_pos      <= res_first_r;
      out_error          <= res_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign in_stall  = state_r != rorc_pkg::S_IDLE;

  // A found position implies a non-empty count.
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_occupied_count != '0)
    else $error("found set with zero occupied count");

  // Errors only come from removes, which never report a position.
  a_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> !out_found && out_occupied_count == '0)
    else $error("error result carries query fields");

  // Range-walk reads are only consumed inside the walk.
  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == rorc_pkg::S_Q_B || state_r == rorc_pkg::S_Q_SH)
    else $error("tree read pending outside range walk");

  // No request is taken during the clearing sweep.
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rorc_pkg::S_CLEAR |-> in_stall)
    else $error("request accepted while clearing");

endmodule

[tb/tb_top.sv]
// Testbench for the reference-count occupancy range counter: random and directed requests.
module tb_top;

  localparam int NPOS       = 1024;
  localparam int CNT_MAX    = 65535;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_REQS = 1527;

  typedef struct packed {
    rorc_pkg::cmd_t cmd;
    logic [9:0]     pos;
    logic [9:0]     lo;
    logic [9:0]     hi;
  } request_t;

  typedef struct packed {
    logic [10:0] occupied_count;
    logic        found;
    logic [9:0]  first_pos;
    logic        error;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [9:0]  in_pos;
  logic [9:0]  in_range_low;
  logic [9:0]  in_range_high;
  logic        out_valid;
  logic        out_stall;
  logic [10:0] out_occupied_count;
  logic        out_found;
  logic [9:0]  out_first_pos;
  logic        out_error;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       shadow_count[NPOS] = '{default: 0};
  bit       stim_done;
  logic     calm;
  int       sent_count = 0;
  int       fail_count = 0;
  int       idle_cycles = 0;

  refcount_occupancy_range_counter DUT (.*);

  // Clock with period 8.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // A long stretch of requests is driven with no idling on either side.
  assign calm = (sent_count >= 500) && (sent_count < 700);

  // Apply one request to the shadow counts and return the answer it should give.
  function automatic answer_t occupancy_predict(request_t r);
    answer_t a;
    int      h;
    a = '0;
    case (r.cmd)
      rorc_pkg::CMD_ADD: begin
        if (shadow_count[r.pos] < CNT_MAX) shadow_count[r.pos]++;
      end
      rorc_pkg::CMD_REMOVE: begin
        if (shadow_count[r.pos] == 0) a.error = 1'b1;
        else shadow_count[r.pos]--;
      end
      rorc_pkg::CMD_QUERY: begin
        h = r.hi;
        for (int p = r.lo; p <= h; p++) begin
          if (shadow_count[p] != 0) begin
            if (!a.found) a.first_pos = p[9:0];
            a.found = 1'b1;
            a.occupied_count++;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic request_t mk_req(rorc_pkg::cmd_t c, int p, int l, int h);
    request_t r;
    r.cmd = c;
    r.pos = p[9:0];
    r.lo  = l[9:0];
    r.hi  = h[9:0];
    return r;
  endfunction

  // Append one request to the driver's queue.
  function automatic void enqueue_req(request_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  // Random request; positions mostly in a small window so counts and ranges interact.
  function automatic request_t random_req();
    int c, p, l, h;
    c = $urandom_range(0, 99);
    p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NPOS - 1) : $urandom_range(0, 63);
    l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NPOS - 1) : $urandom_range(0, 63);
    h = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NPOS - 1) : l + $urandom_range(0, 40);
    if (h > NPOS - 1) h = NPOS - 1;
    return mk_req(c < 40 ? rorc_pkg::CMD_ADD : c < 70 ? rorc_pkg::CMD_REMOVE :
                  c < 97 ? rorc_pkg::CMD_QUERY : rorc_pkg::CMD_NONE, p, l, h);
  endfunction

  // Stimulus: directed corner cases, then random traffic.
  initial begin
    request_t r;
    stim_done = 1'b0;
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 0, 1023));
    enqueue_req(mk_req(rorc_pkg::CMD_REMOVE, 5, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_ADD, 0, 1023, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_ADD, 1023, 0, 1023));
    enqueue_req(mk_req(rorc_pkg::CMD_ADD, 1023, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_ADD, 512, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 0, 1023));
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 1, 1023));
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 1023, 1023));
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 1023, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 513, 1022));
    enqueue_req(mk_req(rorc_pkg::CMD_REMOVE, 1023, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_REMOVE, 1023, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_REMOVE, 1023, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 600, 1023));
    enqueue_req(mk_req(rorc_pkg::CMD_NONE, 1023, 1023, 1023));
    enqueue_req(mk_req(rorc_pkg::CMD_REMOVE, 0, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 0, 0));
    // Stack several references on one position, then step it back down once.
    for (int i = 0; i < 3; i++) enqueue_req(mk_req(rorc_pkg::CMD_ADD, 7, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_REMOVE, 7, 0, 0));
    enqueue_req(mk_req(rorc_pkg::CMD_QUERY, 0, 7, 7));
    wait (pending_reqs.size() == 0);
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = random_req();
      enqueue_req(r);
    end
    stim_done = 1'b1;
  end

  // Driver: presents requests at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_cmd        <= '0;
      in_pos        <= '0;
      in_range_low  <= '0;
      in_range_high <= '0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
        in_valid      <= 1'b1;
        in_cmd        <= pending_reqs[0].cmd;
        in_pos        <= pending_reqs[0].pos;
        in_range_low  <= pending_reqs[0].lo;
        in_range_high <= pending_reqs[0].hi;
        void'(pending_reqs.pop_front());
        sent_count    <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && $urandom_range(0, 99) < 31;
  end

  // Monitor: predicts on accepted requests and checks accepted results.
  always @(posedge clk) begin
    answer_t e;
    request_t r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) begin
        r = mk_req(rorc_pkg::cmd_t'(in_cmd), in_pos, in_range_low, in_range_high);
        expected_answers = {expected_answers, occupancy_predict(r)};
      end
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_answers.pop_front();
          if (out_occupied_count !== e.occupied_count) begin
            $error("occupied_count: expected %0d, got %0d", e.occupied_count,
                   out_occupied_count);
            fail_count++;
          end
          if (out_found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, out_found);
            fail_count++;
          end
          if (out_first_pos !== e.first_pos) begin
            $error("first_pos: expected %0d, got %0d", e.first_pos, out_first_pos);
            fail_count++;
          end
          if (out_error !== e.error) begin
            $error("error: expected %0d, got %0d", e.error, out_error);
            fail_count++;
          end
        end
      end
    end
  end

  // Reset, then wait for the end of traffic or a stalled run.
  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    forever begin
      @(posedge clk);
      if (idle_cycles > STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
      if (stim_done && pending_reqs.size() == 0 && !in_valid
          && expected_answers.size() == 0) begin
        repeat (100) @(posedge clk);
        if (fail_count == 0 && expected_answers.size() == 0) begin
          $display("PASSED: all results match");
        end else begin
          $display("FAILED: results differ");
        end
        $finish;
      end
    end
  end

endmodule
